>>> hw/rtl/oaat_pkg.sv
// ----------------------------------------------------------------------------
// oaat_pkg
// shared constants for the one-at-a-time string hash core
// ----------------------------------------------------------------------------
package oaat_pkg;

  // fixed field widths
  localparam int unsigned ELEM_BITS  = 32;
  localparam int unsigned LEN_BITS   = 32;
  localparam int unsigned HASH_BITS  = 60;
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_LIMIT_MODE     = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_EXPLICIT_LIMIT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_ELEMENT_KIND   = 2'd2;

  // limit mode codes, the unused code acts as the default limit
  localparam logic [1:0] MODE_DEFAULT  = 2'd0;
  localparam logic [1:0] MODE_WHOLE    = 2'd1;
  localparam logic [1:0] MODE_EXPLICIT = 2'd2;

  // element kind codes
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_BYTE = 1'b1;

  // input tuser bit positions
  localparam int unsigned USER_FIRST       = 0;
  localparam int unsigned USER_HAS_ELEMENT = 1;

endpackage

>>> hw/rtl/oaat_finish.sv
// ----------------------------------------------------------------------------
// oaat_finish
// final avalanche and output register of the hash core
// ----------------------------------------------------------------------------
module oaat_finish #(
  parameter int unsigned WORD_BITS = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           raw_valid,
  output logic                           raw_ready,
  input  logic [WORD_BITS-1:0]           raw_word,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [oaat_pkg::HASH_BITS-1:0] digest
);

  logic                           out_valid_r;
  logic                           out_valid_nxt;
  logic [oaat_pkg::HASH_BITS-1:0] hash_r;
  logic [oaat_pkg::HASH_BITS-1:0] hash_nxt;

  logic [WORD_BITS-1:0] h1;
  logic [WORD_BITS-1:0] h2;
  logic [WORD_BITS-1:0] h3;

  // avalanche: shift-add, shift-xor, shift-add, top four bits dropped
  always_comb begin
    h1 = raw_word + (raw_word << 3);
    h2 = h1 ^ (h1 >> 11);
    h3 = h2 + (h2 << 15);
    hash_nxt = oaat_pkg::HASH_BITS'(h3[WORD_BITS-5:0]);
  end

  assign raw_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (raw_ready) begin
      out_valid_nxt = raw_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (raw_valid && raw_ready) begin
      hash_r <= hash_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign digest     = hash_r;

endmodule

>>> hw/rtl/one_at_a_time_string_hash_core.sv
// ----------------------------------------------------------------------------
// one_at_a_time_string_hash_core
// streamed one-at-a-time hash over characters or bytes, length seeded
// ----------------------------------------------------------------------------
// throughput: one element transfer per cycle unless the captured word is stuck
// behind the output, set by the combinational mix loop on the accumulator register
// result path: the last transfer captures the word in raw_r, which then passes
// through the avalanche into the finish output register that drives out_tvalid
// reset: synchronous active-low rst_n clears configuration, state and valids
module one_at_a_time_string_hash_core #(
  parameter int unsigned WORD_BITS  = 64,
  parameter int unsigned CHAR_LIMIT = 64,
  parameter int unsigned BYTE_LIMIT = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration write port
  input  logic                               cfg_we,
  input  logic [oaat_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [oaat_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [63:0]                        in_tdata,   // element, total_length
  input  logic [1:0]                         in_tuser,   // first, has_element
  input  logic                               in_tlast,   // last
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [63:0]                        out_tdata   // digest, zero fill
);

  localparam int unsigned LB = oaat_pkg::LEN_BITS;

  // configuration registers
  logic [1:0]    limit_mode_r;
  logic [LB-1:0] explicit_limit_r;
  logic          element_kind_r;

  // string state
  logic [WORD_BITS-1:0] acc_r;
  logic [WORD_BITS-1:0] acc_nxt;
  logic [LB-1:0]        cnt_r;
  logic [LB-1:0]        cnt_nxt;
  logic [LB-1:0]        lim_r;
  logic [LB-1:0]        lim_nxt;

  // captured pre-avalanche word for the finish stage
  logic                 raw_valid_r;
  logic                 raw_valid_nxt;
  logic [WORD_BITS-1:0] raw_r;
  logic                 raw_ready;

  logic [oaat_pkg::HASH_BITS-1:0] digest;

  // unpacked input fields
  logic [oaat_pkg::ELEM_BITS-1:0] element;
  logic [LB-1:0]                  total_length;
  logic                           first;
  logic                           has_element;
  logic                           in_xfer;

  assign element      = in_tdata[31:0];
  assign total_length = in_tdata[63:32];
  assign first        = in_tuser[oaat_pkg::USER_FIRST];
  assign has_element  = in_tuser[oaat_pkg::USER_HAS_ELEMENT];

  // a new element is taken unless the captured word is stuck behind the output
  assign in_tready = !raw_valid_r || raw_ready;
  assign in_xfer   = in_tvalid && in_tready;

  // configuration writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_mode_r     <= oaat_pkg::MODE_DEFAULT;
      explicit_limit_r <= '0;
      element_kind_r   <= oaat_pkg::KIND_CHAR;
    end else if (cfg_we) begin
      case (cfg_index)
        oaat_pkg::REG_LIMIT_MODE:     limit_mode_r     <= cfg_wdata[1:0];
        oaat_pkg::REG_EXPLICIT_LIMIT: explicit_limit_r <= cfg_wdata[LB-1:0];
        oaat_pkg::REG_ELEMENT_KIND:   element_kind_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  logic [LB-1:0]        mode_limit;
  logic [LB-1:0]        acc_lim;
  logic [LB-1:0]        base_cnt;
  logic [WORD_BITS-1:0] base_acc;
  logic [oaat_pkg::ELEM_BITS-1:0] char_code;
  logic [WORD_BITS-1:0] m1;
  logic [WORD_BITS-1:0] m2;
  logic                 do_mix;

  // limit chosen from the registers current on the first item
  always_comb begin
    case (limit_mode_r)
      oaat_pkg::MODE_WHOLE:    mode_limit = total_length;
      oaat_pkg::MODE_EXPLICIT: mode_limit = explicit_limit_r;
      default: begin
        if (element_kind_r == oaat_pkg::KIND_BYTE) begin
          mode_limit = LB'(BYTE_LIMIT);
        end else begin
          mode_limit = LB'(CHAR_LIMIT);
        end
      end
    endcase
  end

  // first item reseeds the word with the length and restarts the count
  always_comb begin
    if (first) begin
      acc_lim  = (total_length < mode_limit) ? total_length : mode_limit;
      base_cnt = '0;
      base_acc = WORD_BITS'(total_length);
    end else begin
      acc_lim  = lim_r;
      base_cnt = cnt_r;
      base_acc = acc_r;
    end
  end

  // byte kind keeps only the low byte, checked on every item
  assign char_code = (element_kind_r == oaat_pkg::KIND_BYTE) ?
                     {24'd0, element[7:0]} : element;
  assign do_mix = has_element && (base_cnt < acc_lim);

  // one mix step: add, shift-add, shift-xor
  always_comb begin
    m1 = base_acc + WORD_BITS'(char_code);
    m2 = m1 + (m1 << 10);
    if (do_mix) begin
      acc_nxt = m2 ^ (m2 >> 6);
      cnt_nxt = base_cnt + LB'(1);
    end else begin
      acc_nxt = base_acc;
      cnt_nxt = base_cnt;
    end
    lim_nxt = acc_lim;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      cnt_r <= '0;
      lim_r <= '0;
    end else if (in_xfer) begin
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
      lim_r <= lim_nxt;
    end
  end

  // the last transfer hands the word to the finish stage
  always_comb begin
    raw_valid_nxt = raw_valid_r;
    if (in_xfer && in_tlast) begin
      raw_valid_nxt = 1'b1;
    end else if (raw_ready) begin
      raw_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_valid_r <= 1'b0;
    end else begin
      raw_valid_r <= raw_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && in_tlast) begin
      raw_r <= acc_nxt;
    end
  end

  oaat_finish #(
    .WORD_BITS (WORD_BITS)
  ) u_finish (
    .clk        (clk),
    .rst_n      (rst_n),
    .raw_valid  (raw_valid_r),
    .raw_ready  (raw_ready),
    .raw_word   (raw_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .digest     (digest)
  );

  assign out_tdata = {4'd0, digest};

`ifndef SYNTHESIS
  // count never runs past the latched limit
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= lim_r)
    else $error("mixed count exceeds active limit");

  // a last transfer always lands in the finish stage
  a_last_captured: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_tlast) |=> raw_valid_r)
    else $error("last transfer not captured");

  // items without last never create a result
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (!raw_valid_r && !(in_xfer && in_tlast)) |=> !raw_valid_r)
    else $error("spurious captured word");

  // a stalled captured word holds until the output frees
  a_raw_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (raw_valid_r && !raw_ready) |=> (raw_valid_r && $stable(raw_r)))
    else $error("captured word lost while stalled");
`endif

endmodule
